### rtl/twtb_pkg.sv
// Shared types, constants and helpers for the time window track buffer.
// Used by twtb_cfg, twtb_ctrl and the top unit; depends on nothing else.
package twtb_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POP_W  = $clog2(DEPTH + 2);

  localparam int TS_W        = 42;
  localparam int ID_W        = 32;
  localparam int OP_W        = 2;
  localparam int MAXSZ_W     = 11;
  localparam int WIN_W       = 14;
  localparam int COUNT_OUT_W = 11;
  localparam int WMS_W       = 36;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 14;

  localparam int IN_DATA_W    = 48;
  localparam int OUT_FIELDS_W = 1 + ID_W + 1 + ID_W + ID_W + COUNT_OUT_W + TS_W + TS_W;
  localparam int OUT_DATA_W   = 200;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  // bit positions of result fields in the output word
  localparam int OUT_PVALID    = 1 + ID_W;
  localparam int OUT_PFIRST_LO = OUT_PVALID + 1;
  localparam int OUT_PLAST_LO  = OUT_PFIRST_LO + ID_W;
  localparam int OUT_COUNT_LO  = OUT_PLAST_LO + ID_W;
  localparam int OUT_OLDEST_LO = OUT_COUNT_LO + COUNT_OUT_W;
  localparam int OUT_NEWEST_LO = OUT_OLDEST_LO + TS_W;

  localparam int SECONDS_PER_HOUR = 60 * 60;
  localparam logic [WMS_W-1:0] MS_PER_HOUR = WMS_W'(SECONDS_PER_HOUR * 1000);

  localparam int WIN_RESET_HOURS = 24;
  localparam int MAXSZ_RESET     = 1024;
  localparam logic [WMS_W-1:0] WIN_RESET_MS = WMS_W'(WIN_RESET_HOURS) * MS_PER_HOUR;
  localparam logic [CNT_W-1:0] LIM_RESET =
    CNT_W'((DEPTH < MAXSZ_RESET) ? DEPTH : MAXSZ_RESET);

  localparam logic [CFG_IDX_W-1:0] REG_MAX_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_TRIM  = 2'd2
  } op_t;

  typedef struct packed {
    logic [CNT_W-1:0] lim;
    logic [WMS_W-1:0] window_ms;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [TS_W-1:0]   data;
  } mem_wr_t;

  // ring position a + b, with b at most DEPTH
  function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
    if (s >= (CNT_W+1)'(DEPTH)) begin
      s = s - (CNT_W+1)'(DEPTH);
    end
    return s[ADDR_W-1:0];
  endfunction

endpackage

### rtl/twtb_ram.sv
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// Standalone; no package dependency.
module twtb_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/twtb_cfg.sv
// Configuration registers: clamped size limit and window converted to ms.
// Depends on twtb_pkg.
module twtb_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [twtb_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [twtb_pkg::CFG_DATA_W-1:0]  cfg_data,
  output twtb_pkg::cfg_t                   cfg
);
  import twtb_pkg::*;

  logic [MAXSZ_W-1:0] size_in;

  assign size_in = cfg_data[MAXSZ_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lim       <= LIM_RESET;
      cfg.window_ms <= WIN_RESET_MS;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MAX_SIZE: begin
          if (size_in == '0) begin
            cfg.lim <= CNT_W'(1);
          end else if (32'(size_in) > 32'(DEPTH)) begin
            cfg.lim <= CNT_W'(DEPTH);
          end else begin
            cfg.lim <= CNT_W'(size_in);
          end
        end
        REG_WINDOW: begin
          cfg.window_ms <= WMS_W'(cfg_data[WIN_W-1:0]) * MS_PER_HOUR;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/twtb_ctrl.sv
// Sequencer: decodes ops, walks the ring front for eviction, appends points,
// and holds the output word. Depends on twtb_pkg; drives the time RAM ports.
module twtb_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  twtb_pkg::cfg_t                   cfg,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [twtb_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic [twtb_pkg::OP_W-1:0]        s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [twtb_pkg::OUT_DATA_W-1:0]  m_tdata,
  output twtb_pkg::mem_wr_t                mem_wr,
  output logic [twtb_pkg::ADDR_W-1:0]      mem_raddr,
  input  logic [twtb_pkg::TS_W-1:0]        mem_rdata
);
  import twtb_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_WALK, S_DONE} state_t;

  state_t            state;
  op_t               op_r;
  logic [TS_W-1:0]   ts_r;
  logic              rst_ids_r;
  logic [ADDR_W-1:0] head;
  logic [ADDR_W-1:0] head_next;
  logic [CNT_W-1:0]  count;
  logic [ID_W-1:0]   next_id;
  logic [TS_W-1:0]   newest;
  logic [TS_W-1:0]   bound;
  logic              age_en;
  logic              extra;
  logic [POP_W-1:0]  npop;
  logic [ID_W-1:0]   base;
  logic              added;
  logic [ID_W-1:0]   added_id;
  logic              fwd_hit;
  logic [TS_W-1:0]   fwd_data;

  logic [TS_W-1:0]   front;
  logic              is_add;
  logic              add_ok;
  logic [TS_W-1:0]   nv;
  logic [TS_W-1:0]   wms;
  logic              age_ok;
  logic              flush;
  logic              drop_all;
  logic              walk_pop;
  logic              popped;
  logic [ID_W-1:0]   pfirst;
  logic [ID_W-1:0]   plast;
  logic [TS_W-1:0]   oldest_o;
  logic [TS_W-1:0]   newest_o;

  // head entry, with bypass for a write that landed on it last cycle
  assign front = fwd_hit ? fwd_data : mem_rdata;

  always_comb begin
    is_add   = (op_r == OP_ADD);
    add_ok   = (count == '0) || (newest <= ts_r);
    nv       = is_add ? ts_r : newest;
    wms      = TS_W'(cfg.window_ms);
    age_ok   = (wms <= nv);
    // zero window with an older front point drops everything
    flush    = (state == S_EVAL) && (count != '0) && (wms == '0) && (front < nv) &&
               ((is_add && add_ok) || (op_r == OP_TRIM));
    drop_all = flush || ((state == S_EVAL) && (op_r == OP_CLEAR));
    walk_pop = (state == S_WALK) && (count != '0) &&
               ((age_en && (front < bound)) ||
                (((CNT_W+1)'(count) + (CNT_W+1)'(extra)) > (CNT_W+1)'(cfg.lim)));
    if (drop_all) begin
      head_next = ring_add(head, count);
    end else if (walk_pop) begin
      head_next = ring_add(head, CNT_W'(1));
    end else begin
      head_next = head;
    end
    mem_wr.we   = (state == S_WALK) && !walk_pop && extra;
    mem_wr.addr = ring_add(head, count);
    mem_wr.data = ts_r;
  end

  assign mem_raddr = head_next;
  assign s_tready  = (state == S_IDLE);

  always_comb begin
    popped   = (npop != '0);
    pfirst   = popped ? base : '0;
    plast    = popped ? (base + ID_W'(npop) - ID_W'(1)) : '0;
    oldest_o = (count != '0) ? front : '0;
    newest_o = (count != '0) ? newest : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      count    <= '0;
      next_id  <= '0;
      m_tvalid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      head     <= head_next;
      fwd_hit  <= mem_wr.we && (mem_wr.addr == head_next);
      fwd_data <= ts_r;
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_r      <= op_t'(s_tuser);
            ts_r      <= s_tdata[TS_W-1:0];
            rst_ids_r <= s_tdata[TS_W];
            added     <= 1'b0;
            added_id  <= '0;
            npop      <= '0;
            base      <= next_id - ID_W'(count);
            state     <= S_EVAL;
          end
        end
        S_EVAL: begin
          bound  <= nv - wms;
          age_en <= age_ok;
          extra  <= is_add;
          state  <= S_DONE;
          case (op_r)
            OP_ADD: begin
              if (add_ok) begin
                added    <= 1'b1;
                added_id <= next_id;
                next_id  <= next_id + ID_W'(1);
                if (flush) begin
                  npop  <= POP_W'(count) + POP_W'(1);
                  count <= '0;
                end else begin
                  state <= S_WALK;
                end
              end
            end
            OP_CLEAR: begin
              npop  <= POP_W'(count);
              count <= '0;
              if (rst_ids_r) begin
                next_id <= '0;
              end
            end
            OP_TRIM: begin
              if (flush) begin
                npop  <= POP_W'(count);
                count <= '0;
              end else if (count != '0) begin
                state <= S_WALK;
              end
            end
            default: begin
            end
          endcase
        end
        S_WALK: begin
          if (walk_pop) begin
            count <= count - CNT_W'(1);
            npop  <= npop + POP_W'(1);
          end else begin
            if (extra) begin
              count  <= count + CNT_W'(1);
              newest <= ts_r;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {OUT_PAD_W'(0), newest_o, oldest_o, COUNT_OUT_W'(count),
                         plast, pfirst, popped, added_id, added};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/time_window_track_buffer_unit.sv
// Time window track buffer: keeps up to 1024 track-point timestamps (ms) in a
// ring RAM with consecutive 32-bit IDs, evicting by age window and size limit.
// An add or a trim that walks the ring front goes from idle through the
// evaluate and walk states to the done state; an add or a trim that a zero
// window empties at once, a trim of an empty buffer, a clear, a rejected add
// and an unused op go from evaluate straight to done. A new input word is
// taken only in the idle state. The eviction walk reads one front entry per
// cycle through the single read port of the time RAM, and each point is
// evicted once. A result waiting in the output register does not hold off the
// next input word, but the following result stalls until it has moved. The
// time RAM needs no clearing after reset. Depends on twtb_pkg, twtb_cfg,
// twtb_ctrl and twtb_ram.
module time_window_track_buffer_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [twtb_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [twtb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // timestamp[41:0], reset_ids[42], zero pad [47:43]
  input  logic [twtb_pkg::IN_DATA_W-1:0]   s_tdata,
  // op[1:0]
  input  logic [twtb_pkg::OP_W-1:0]        s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // added[0], added_id[32:1], popped_valid[33], popped_first[65:34],
  // popped_last[97:66], stored_count[108:98], oldest_time[150:109],
  // newest_time[192:151], zero pad [199:193]
  output logic [twtb_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import twtb_pkg::*;

  cfg_t              cfg;
  mem_wr_t           mem_wr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [TS_W-1:0]   mem_rdata;

  twtb_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  twtb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .mem_wr    (mem_wr),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  twtb_ram #(
    .WIDTH (TS_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_wr.we),
    .waddr (mem_wr.addr),
    .wdata (mem_wr.data),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a word is in progress");

  a_write_then_done: assert property (@(posedge clk) disable iff (rst)
    mem_wr.we |=> !s_tready)
    else $error("ram write not followed by result stage");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (32'(m_tdata[OUT_OLDEST_LO-1:OUT_COUNT_LO]) <= 32'(DEPTH)))
    else $error("stored count above depth");

  a_time_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OUT_OLDEST_LO+TS_W-1:OUT_OLDEST_LO] <=
                  m_tdata[OUT_NEWEST_LO+TS_W-1:OUT_NEWEST_LO]))
    else $error("oldest time after newest time");

  a_pop_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[OUT_PVALID]) |->
      (m_tdata[OUT_COUNT_LO-1:OUT_PFIRST_LO] == '0))
    else $error("popped range set with nothing evicted");
`endif

endmodule
